// File: hdl/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg: shared types and constants for the Markov cohort step block
// Field widths, fixed-point limits, request codes and the control bundle
// that the sequencer hands to the accumulator bank.
// ----------------------------------------------------------------------------
package mcs_pkg;

  // Field widths of the request and result channels.
  localparam int IDX_W  = 4;   // state index field
  localparam int VAL_W  = 32;  // occupancy, unsigned Q16.16
  localparam int CNT_W  = 5;   // states_in_use register
  localparam int PROB_W = 17;  // probability after clamping, Q1.16 up to 1.0
  localparam int ACC_W  = 40;  // accumulator, unsigned Q24.16

  // Product of occupancy and probability as the serial multiplier leaves it.
  localparam int PROD_HI_W = VAL_W + 1;         // upper part, weight 2^PROB_W
  localparam int RND_W     = PROD_HI_W + 1;     // product with bit 16, i.e. >> 16
  localparam int STEP_W    = $clog2(PROB_W + 1);

  // Design limits and reset values.
  localparam int MAX_STATES_DEF = 16;
  localparam int STATE_CAP      = 16;           // largest state count the fields can name
  localparam logic [CNT_W-1:0]  STATES_RESET = CNT_W'(16);
  localparam logic [PROB_W-1:0] ONE_Q16      = PROB_W'(65536);

  // Request kinds.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ENTRY = 1'b1;

  // Control from the sequencer to the accumulator bank.
  typedef struct packed {
    logic             add_en;     // add the rounded product into the selected entry
    logic             clear_all;  // clear every accumulator
    logic [IDX_W-1:0] idx;        // entry to read and update
  } acc_ctl_t;

endpackage

// File: hdl/mcs_mul.sv
// ----------------------------------------------------------------------------
// mcs_mul: bit-serial occupancy by probability multiplier
// Consumes one probability bit per cycle, least significant first, with a
// single narrow adder. After PROB_W steps it offers the product shifted down
// by 16 bits together with the rounding carry for round half up.
// ----------------------------------------------------------------------------
module mcs_mul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [mcs_pkg::VAL_W-1:0]       occ_in,
  input  logic [mcs_pkg::PROB_W-1:0]      prob_in,
  output logic                            done,
  output logic [mcs_pkg::RND_W-1:0]       rnd_base,
  output logic                            rnd_cin
);

  logic                               run_r,  run_nxt;
  logic [mcs_pkg::STEP_W-1:0]         cnt_r,  cnt_nxt;
  logic [mcs_pkg::VAL_W-1:0]          occ_r,  occ_nxt;
  logic [mcs_pkg::PROB_W-1:0]         prob_r, prob_nxt;
  logic [mcs_pkg::PROD_HI_W-1:0]      hi_r,   hi_nxt;
  logic [mcs_pkg::PROB_W-1:0]         lo_r,   lo_nxt;
  logic [mcs_pkg::PROD_HI_W:0]        step_sum;

  // One shift-and-add step: add the multiplicand when the current bit is set.
  assign step_sum = {1'b0, hi_r} +
                    (prob_r[0] ? (mcs_pkg::PROD_HI_W + 1)'(occ_r)
                               : '0);

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    occ_nxt  = occ_r;
    prob_nxt = prob_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (start) begin
      run_nxt  = 1'b1;
      cnt_nxt  = mcs_pkg::STEP_W'(mcs_pkg::PROB_W);
      occ_nxt  = occ_in;
      prob_nxt = prob_in;
      hi_nxt   = '0;
      lo_nxt   = '0;
    end else if (run_r && (cnt_r != '0)) begin
      cnt_nxt  = cnt_r - mcs_pkg::STEP_W'(1);
      prob_nxt = prob_r >> 1;
      hi_nxt   = step_sum[mcs_pkg::PROD_HI_W:1];
      lo_nxt   = {step_sum[0], lo_r[mcs_pkg::PROB_W-1:1]};
    end else if (run_r) begin
      // The finished product has been offered for one cycle.
      run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    occ_r  <= occ_nxt;
    prob_r <= prob_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
  end

  // Adding 2^15 to the product and shifting by 16 equals taking bits 16 and
  // up and adding bit 15 as a carry.
  assign done     = run_r && (cnt_r == '0);
  assign rnd_base = {hi_r, lo_r[mcs_pkg::PROB_W-1]};
  assign rnd_cin  = lo_r[mcs_pkg::PROB_W-2];

endmodule

// File: hdl/mcs_acc_bank.sv
// ----------------------------------------------------------------------------
// mcs_acc_bank: accumulators of the next occupancy vector
// Holds one saturating Q24.16 accumulator per state. The selected entry is
// read out, can take a rounded product, and all entries clear together when
// the vector has been emitted.
// ----------------------------------------------------------------------------
module mcs_acc_bank #(
  parameter int DEPTH = mcs_pkg::STATE_CAP
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mcs_pkg::acc_ctl_t             ctl,
  input  logic [mcs_pkg::RND_W-1:0]     addend,
  input  logic                          addend_cin,
  output logic [mcs_pkg::ACC_W-1:0]     rd_data
);

  localparam int IW = $clog2(DEPTH);

  logic [mcs_pkg::ACC_W-1:0] acc_r [DEPTH];
  logic [IW-1:0]             sel;
  logic [mcs_pkg::ACC_W:0]   sum;
  logic [mcs_pkg::ACC_W-1:0] sum_sat;

  assign sel     = ctl.idx[IW-1:0];
  assign rd_data = acc_r[sel];

  // Add with the rounding carry folded in, then clamp at the top of range.
  assign sum     = {1'b0, acc_r[sel]} + (mcs_pkg::ACC_W + 1)'(addend) +
                   (mcs_pkg::ACC_W + 1)'(addend_cin);
  assign sum_sat = sum[mcs_pkg::ACC_W] ? '1 : sum[mcs_pkg::ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear_all) begin
      for (int i = 0; i < DEPTH; i++) begin
        acc_r[i] <= '0;
      end
    end else if (ctl.add_en) begin
      acc_r[sel] <= sum_sat;
    end
  end

endmodule

// File: hdl/markov_cohort_step.sv
// ----------------------------------------------------------------------------
// markov_cohort_step: one propagation step of a Markov cohort vector
// Load requests set occupancy; entry requests multiply-accumulate into the
// next vector; the closing entry emits the new vector one element a cycle
// while the result side does not stall. An in-range entry passes through
// the accept, the 17-step bit-serial multiplier and the accumulate; a load
// or an out-of-range entry needs no multiply.
// Throughput: one request at a time; a closing entry then emits n
// elements, one per free output slot.
// Reset (synchronous, active low) clears occupancy and accumulators and
// sets the state count to 16.
// ----------------------------------------------------------------------------
module markov_cohort_step #(
  parameter int MAX_STATES = mcs_pkg::MAX_STATES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [mcs_pkg::IDX_W-1:0]     in_from_state,
  input  logic [mcs_pkg::IDX_W-1:0]     in_to_state,
  input  logic [mcs_pkg::VAL_W-1:0]     in_item_value,
  input  logic                          in_end_of_matrix,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mcs_pkg::IDX_W-1:0]     out_state_index,
  output logic [mcs_pkg::VAL_W-1:0]     out_occupancy,
  output logic                          out_clipped,
  output logic                          out_last_of_run,
  // Configuration
  input  logic                          cfg_wr_en,
  input  logic [mcs_pkg::CNT_W-1:0]     cfg_wr_data
);

  localparam int CAP = (MAX_STATES < mcs_pkg::STATE_CAP) ? MAX_STATES
                                                          : mcs_pkg::STATE_CAP;
  localparam int IW  = $clog2(CAP);
  localparam logic [mcs_pkg::CNT_W-1:0] CAP_N = mcs_pkg::CNT_W'(CAP);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                         st_r, st_nxt;
  logic [mcs_pkg::CNT_W-1:0]      states_r;
  logic [mcs_pkg::CNT_W-1:0]      n_eff;
  logic [mcs_pkg::VAL_W-1:0]      occ_r [CAP];
  logic [mcs_pkg::IDX_W-1:0]      dst_r, dst_nxt;
  logic                           last_r, last_nxt;
  logic [IW-1:0]                  k_r, k_nxt;
  logic                           in_accept;
  logic                           from_ok, to_ok;
  logic [mcs_pkg::PROB_W-1:0]     prob_sat;
  logic                           mul_start, mul_done;
  logic [mcs_pkg::RND_W-1:0]      rnd_base;
  logic                           rnd_cin;
  mcs_pkg::acc_ctl_t              acc_ctl;
  logic [mcs_pkg::ACC_W-1:0]      acc_rd;
  logic                           slot_free;
  logic                           emit_go;
  logic                           emit_last;
  logic                           emit_clip;
  logic [mcs_pkg::VAL_W-1:0]      emit_val;
  logic                           out_valid_r;
  logic [mcs_pkg::IDX_W-1:0]      out_idx_r;
  logic [mcs_pkg::VAL_W-1:0]      out_occ_r;
  logic                           out_clip_r;
  logic                           out_last_r;

  // Effective state count: the register clamped to 1 .. CAP.
  always_comb begin
    if (states_r == '0) begin
      n_eff = mcs_pkg::CNT_W'(1);
    end else if (states_r > CAP_N) begin
      n_eff = CAP_N;
    end else begin
      n_eff = states_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      states_r <= mcs_pkg::STATES_RESET;
    end else if (cfg_wr_en) begin
      states_r <= cfg_wr_data;
    end
  end

  // Requests are taken only between pieces of work.
  assign in_stall  = (st_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign from_ok   = ({1'b0, in_from_state} < n_eff);
  assign to_ok     = ({1'b0, in_to_state} < n_eff);
  assign prob_sat  = (in_item_value > mcs_pkg::VAL_W'(mcs_pkg::ONE_Q16))
                     ? mcs_pkg::ONE_Q16
                     : in_item_value[mcs_pkg::PROB_W-1:0];
  assign mul_start = in_accept && (in_req_type == mcs_pkg::REQ_ENTRY) &&
                     from_ok && to_ok;

  mcs_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_start),
    .occ_in   (occ_r[in_from_state[IW-1:0]]),
    .prob_in  (prob_sat),
    .done     (mul_done),
    .rnd_base (rnd_base),
    .rnd_cin  (rnd_cin)
  );

  // Emission: one element per free output slot.
  assign slot_free = !out_valid_r || !out_stall;
  assign emit_go   = (st_r == ST_EMIT) && slot_free;
  assign emit_last = (mcs_pkg::CNT_W'(k_r) == (n_eff - mcs_pkg::CNT_W'(1)));
  assign emit_clip = (acc_rd[mcs_pkg::ACC_W-1:mcs_pkg::VAL_W] != '0);
  assign emit_val  = emit_clip ? '1 : acc_rd[mcs_pkg::VAL_W-1:0];

  // Accumulator bank control.
  always_comb begin
    acc_ctl.add_en    = (st_r == ST_MUL) && mul_done;
    acc_ctl.clear_all = emit_go && emit_last;
    acc_ctl.idx       = (st_r == ST_EMIT) ? mcs_pkg::IDX_W'(k_r) : dst_r;
  end

  mcs_acc_bank #(
    .DEPTH (CAP)
  ) u_acc_bank (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (acc_ctl),
    .addend     (rnd_base),
    .addend_cin (rnd_cin),
    .rd_data    (acc_rd)
  );

  // Sequencer.
  always_comb begin
    st_nxt   = st_r;
    dst_nxt  = dst_r;
    last_nxt = last_r;
    k_nxt    = k_r;
    case (st_r)
      ST_IDLE: begin
        if (in_accept && (in_req_type == mcs_pkg::REQ_ENTRY)) begin
          dst_nxt  = in_to_state;
          last_nxt = in_end_of_matrix;
          k_nxt    = '0;
          if (from_ok && to_ok) begin
            st_nxt = ST_MUL;
          end else if (in_end_of_matrix) begin
            st_nxt = ST_EMIT;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          st_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          if (emit_last) begin
            st_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + IW'(1);
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      k_r  <= '0;
    end else begin
      st_r <= st_nxt;
      k_r  <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dst_r  <= dst_nxt;
    last_r <= last_nxt;
  end

  // Occupancy vector: written by loads and by emitted elements.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CAP; i++) begin
        occ_r[i] <= '0;
      end
    end else if (emit_go) begin
      occ_r[k_r] <= emit_val;
    end else if (in_accept && (in_req_type == mcs_pkg::REQ_LOAD) && from_ok) begin
      occ_r[in_from_state[IW-1:0]] <= in_item_value;
    end
  end

  // Output register: holds an element until the result side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_idx_r  <= mcs_pkg::IDX_W'(k_r);
      out_occ_r  <= emit_val;
      out_clip_r <= emit_clip;
      out_last_r <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_state_index = out_idx_r;
  assign out_occupancy   = out_occ_r;
  assign out_clipped     = out_clip_r;
  assign out_last_of_run = out_last_r;

  // The vector's final element carries the highest active index.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run) |->
      ({1'b0, out_state_index} == (n_eff - mcs_pkg::CNT_W'(1))))
    else $error("last_of_run on an element other than the final active state");

  // A clipped element is always pinned at full scale.
  a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |-> (&out_occupancy))
    else $error("clipped element not saturated");

  // The multiplier only finishes while the sequencer waits for it.
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (st_r == ST_MUL))
    else $error("multiplier finished outside the multiply phase");

  // An in-range entry always puts the sequencer into the multiply phase in the next cycle.
  a_entry_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |=> (st_r == ST_MUL))
    else $error("in-range entry did not start a multiply");

endmodule
